>>> design/shared_pool_linked_byte_queues_assert.svh
// Assertion macros for the shared pool byte queue manager.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef SHARED_POOL_LINKED_BYTE_QUEUES_ASSERT_SVH
`define SHARED_POOL_LINKED_BYTE_QUEUES_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define SPLQ_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("splq: implication check failed");

// Next-cycle implication, checked outside reset
`define SPLQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("splq: next-cycle check failed");

`endif

>>> design/splq_pkg.sv
// Shared types, constants and helpers for the shared pool byte queue manager.
// No dependencies.
package splq_pkg;

  // Pool geometry
  localparam int BYTES_PER_BLOCK = 8;
  localparam int NUM_BLOCKS      = 256;
  localparam int OFS_W           = $clog2(BYTES_PER_BLOCK);
  localparam int BLK_W           = $clog2(NUM_BLOCKS);
  localparam int PTR_W           = BLK_W + OFS_W;
  localparam int POOL_BYTES      = NUM_BLOCKS * BYTES_PER_BLOCK;
  localparam int LINK_OFS        = BYTES_PER_BLOCK - 1;

  // Field widths
  localparam int OPCODE_W = 2;
  localparam int ID_W     = 8;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 2;

  localparam int IN_FIELDS_W  = OPCODE_W + ID_W + BYTE_W;
  localparam int OUT_FIELDS_W = STATUS_W + ID_W + BYTE_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [OPCODE_W-1:0] {
    OP_CREATE  = 2'd0,
    OP_DESTROY = 2'd1,
    OP_ENQUEUE = 2'd2,
    OP_DEQUEUE = 2'd3
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_NOMEM = 2'd1,
    ST_EMPTY = 2'd2,
    ST_BADID = 2'd3
  } status_e;

  // Byte address of the link byte of a block
  function automatic logic [PTR_W-1:0] link_addr(input logic [BLK_W-1:0] blk);
    link_addr = {blk, OFS_W'(LINK_OFS)};
  endfunction

  // Byte address of the first data byte of a block
  function automatic logic [PTR_W-1:0] block_base(input logic [BLK_W-1:0] blk);
    block_base = {blk, {OFS_W{1'b0}}};
  endfunction

endpackage

>>> design/splq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module splq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write, and register read data (old contents on a same-address write)
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/shared_pool_linked_byte_queues.sv
// Many byte queues over one pool of linked fixed-size blocks, with a free list.
// Uses splq_pkg, splq_ram and the assertion macro header.
//
// Usage: one command enters on the s_axis channel (create, destroy, enqueue,
// dequeue) and exactly one result leaves on the m_axis channel. A single
// sequencer walks each command through the pool memory, the head/tail pointer
// memories and the free-list/high-water allocator, so only one command is in
// flight; s_axis_tready_o is high only while the sequencer is idle.
// Each block holds BYTES_PER_BLOCK-1 data bytes and a link byte to the next.
// Enqueue takes longer when a new block is taken, dequeue when it crosses a
// block boundary; a bad id or an empty queue finishes soonest, and create
// takes a descriptor and then a data block. A new command can be accepted in
// the cycle after the result is loaded. The pacing is set by the single write
// port and the registered read of the pool memory: every link lookup waits
// for the registered read before its value is usable.
// Reset clears the free list, the high-water counter and the live flag of
// every descriptor; the memories are not cleared and need no sweep.
// The result sits in an output register; while the receiver stalls, the block
// still accepts and works one more command, then holds until the register
// frees up.
`include "shared_pool_linked_byte_queues_assert.svh"

module shared_pool_linked_byte_queues
  import splq_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // [1:0] opcode, [9:2] queue_id, [17:10] value, rest zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // [1:0] status, [9:2] new_queue_id, [17:10] read_byte, rest zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOK,
    S_TAKE_REQ,
    S_TAKE_WAIT,
    S_C_GOT_D,
    S_C_GOT_F,
    S_D_TAIL,
    S_D_GIVE,
    S_E_GOT,
    S_E_WR,
    S_Q_LINK,
    S_Q_DATA,
    S_DONE
  } state_e;

  localparam logic [BLK_W-1:0] HW_MAX = BLK_W'(NUM_BLOCKS - 1);

  state_e                 state_q;
  state_e                 ret_q;
  opcode_e                op_q;
  logic [ID_W-1:0]        id_q;
  logic [BYTE_W-1:0]      val_q;
  logic [PTR_W-1:0]       h_q;
  logic [PTR_W-1:0]       t_q;
  logic [BLK_W-1:0]       blk_q;
  logic [BLK_W-1:0]       d_q;
  logic [BLK_W-1:0]       free_head_q;
  logic [BLK_W-1:0]       hw_q;
  logic [NUM_BLOCKS-1:0]  live_q;
  status_e                res_status_q;
  logic [ID_W-1:0]        res_newid_q;
  logic [BYTE_W-1:0]      res_rbyte_q;
  logic                   m_valid_q;
  logic [OUT_TDATA_W-1:0] m_data_q;
  logic                   res_load;

  // Input fields
  opcode_e           in_op;
  logic [ID_W-1:0]   in_id;
  logic [BYTE_W-1:0] in_val;
  logic              in_fire;

  assign in_op   = opcode_e'(s_axis_tdata_i[OPCODE_W-1:0]);
  assign in_id   = s_axis_tdata_i[OPCODE_W +: ID_W];
  assign in_val  = s_axis_tdata_i[OPCODE_W+ID_W +: BYTE_W];
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;

  // Load the output register when the finished result fits
  assign res_load = (state_q == S_DONE) && (!m_valid_q || m_axis_tready_i);

  logic [BLK_W-1:0] id_blk;
  logic             bad_id;

  assign id_blk = id_q[BLK_W-1:0];
  assign bad_id = (id_q == '0) || (int'(id_q) >= NUM_BLOCKS) || !live_q[id_blk];

  // Memory ports
  logic              pool_we;
  logic [PTR_W-1:0]  pool_waddr;
  logic [BYTE_W-1:0] pool_wdata;
  logic [PTR_W-1:0]  pool_raddr;
  logic [BYTE_W-1:0] pool_rdata;
  logic              head_we;
  logic              tail_we;
  logic [BLK_W-1:0]  ptr_waddr;
  logic [PTR_W-1:0]  ptr_wdata;
  logic [BLK_W-1:0]  ptr_raddr;
  logic [PTR_W-1:0]  head_rdata;
  logic [PTR_W-1:0]  tail_rdata;

  logic [BLK_W-1:0]  link_blk;

  assign link_blk = pool_rdata[BLK_W-1:0];

  // Look up the pointers of the incoming id while idle
  assign ptr_raddr = (state_q == S_IDLE) ? in_id[BLK_W-1:0] : id_blk;

  // Pool port selection per sequencer step
  always_comb begin
    pool_we    = 1'b0;
    pool_waddr = link_addr(free_head_q);
    pool_wdata = BYTE_W'(free_head_q);
    pool_raddr = link_addr(free_head_q);
    unique case (state_q)
      S_LOOK: begin
        pool_raddr = head_rdata;
      end
      S_C_GOT_F: begin
        // return the descriptor when no data block is left
        pool_we    = (blk_q == '0);
        pool_waddr = link_addr(d_q);
      end
      S_D_TAIL: begin
        pool_we    = 1'b1;
        pool_waddr = link_addr(t_q[PTR_W-1:OFS_W]);
      end
      S_D_GIVE: begin
        pool_we    = 1'b1;
        pool_waddr = link_addr(id_blk);
        pool_wdata = BYTE_W'(h_q[PTR_W-1:OFS_W]);
      end
      S_E_GOT: begin
        pool_we    = (blk_q != '0);
        pool_waddr = t_q;
        pool_wdata = BYTE_W'(blk_q);
      end
      S_E_WR: begin
        pool_we    = 1'b1;
        pool_waddr = t_q;
        pool_wdata = val_q;
      end
      S_Q_LINK: begin
        pool_we    = 1'b1;
        pool_waddr = link_addr(h_q[PTR_W-1:OFS_W]);
        pool_raddr = block_base(link_blk);
      end
      default: begin
      end
    endcase
  end

  // Pointer memory writes
  always_comb begin
    head_we   = 1'b0;
    tail_we   = 1'b0;
    ptr_waddr = id_blk;
    ptr_wdata = h_q + 1'b1;
    unique case (state_q)
      S_C_GOT_F: begin
        head_we   = (blk_q != '0);
        tail_we   = (blk_q != '0);
        ptr_waddr = d_q;
        ptr_wdata = block_base(blk_q);
      end
      S_E_WR: begin
        tail_we   = 1'b1;
        ptr_wdata = t_q + 1'b1;
      end
      S_Q_DATA: begin
        head_we   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  splq_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (POOL_BYTES)
  ) u_pool_ram (
    .clk_i   (clk_i),
    .we_i    (pool_we),
    .waddr_i (pool_waddr),
    .wdata_i (pool_wdata),
    .raddr_i (pool_raddr),
    .rdata_o (pool_rdata)
  );

  splq_ram #(
    .WIDTH (PTR_W),
    .DEPTH (NUM_BLOCKS)
  ) u_head_ram (
    .clk_i   (clk_i),
    .we_i    (head_we),
    .waddr_i (ptr_waddr),
    .wdata_i (ptr_wdata),
    .raddr_i (ptr_raddr),
    .rdata_o (head_rdata)
  );

  splq_ram #(
    .WIDTH (PTR_W),
    .DEPTH (NUM_BLOCKS)
  ) u_tail_ram (
    .clk_i   (clk_i),
    .we_i    (tail_we),
    .waddr_i (ptr_waddr),
    .wdata_i (ptr_wdata),
    .raddr_i (ptr_raddr),
    .rdata_o (tail_rdata)
  );

  // Sequencer, allocator state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      free_head_q <= '0;
      hw_q        <= '0;
      live_q      <= '0;
      m_valid_q   <= 1'b0;
    end else begin
      // load a new result, or drop the old one once the receiver takes it
      if (res_load) begin
        m_valid_q <= 1'b1;
      end else if (m_valid_q && m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            op_q         <= in_op;
            id_q         <= in_id;
            val_q        <= in_val;
            res_status_q <= ST_OK;
            res_newid_q  <= '0;
            res_rbyte_q  <= '0;
            if (in_op == OP_CREATE) begin
              ret_q   <= S_C_GOT_D;
              state_q <= S_TAKE_REQ;
            end else begin
              state_q <= S_LOOK;
            end
          end
        end
        S_LOOK: begin
          h_q <= head_rdata;
          t_q <= tail_rdata;
          if (bad_id) begin
            res_status_q <= ST_BADID;
            state_q      <= S_DONE;
          end else begin
            unique case (op_q)
              OP_DESTROY: state_q <= S_D_TAIL;
              OP_ENQUEUE: begin
                if (tail_rdata[OFS_W-1:0] == OFS_W'(LINK_OFS)) begin
                  ret_q   <= S_E_GOT;
                  state_q <= S_TAKE_REQ;
                end else begin
                  state_q <= S_E_WR;
                end
              end
              OP_DEQUEUE: begin
                if (head_rdata == tail_rdata) begin
                  res_status_q <= ST_EMPTY;
                  state_q      <= S_DONE;
                end else if (head_rdata[OFS_W-1:0] == OFS_W'(LINK_OFS)) begin
                  state_q <= S_Q_LINK;
                end else begin
                  state_q <= S_Q_DATA;
                end
              end
              OP_CREATE: state_q <= S_DONE;
            endcase
          end
        end
        // take a block: free list first, then the high-water counter
        S_TAKE_REQ: begin
          priority if (free_head_q != '0) begin
            blk_q   <= free_head_q;
            state_q <= S_TAKE_WAIT;
          end else if (hw_q < HW_MAX) begin
            hw_q    <= hw_q + 1'b1;
            blk_q   <= hw_q + 1'b1;
            state_q <= ret_q;
          end else begin
            blk_q   <= '0;
            state_q <= ret_q;
          end
        end
        S_TAKE_WAIT: begin
          free_head_q <= link_blk;
          state_q     <= ret_q;
        end
        S_C_GOT_D: begin
          if (blk_q == '0) begin
            res_status_q <= ST_NOMEM;
            state_q      <= S_DONE;
          end else begin
            d_q     <= blk_q;
            ret_q   <= S_C_GOT_F;
            state_q <= S_TAKE_REQ;
          end
        end
        S_C_GOT_F: begin
          if (blk_q == '0) begin
            free_head_q  <= d_q;
            res_status_q <= ST_NOMEM;
          end else begin
            live_q[d_q] <= 1'b1;
            res_newid_q <= ID_W'(d_q);
          end
          state_q <= S_DONE;
        end
        S_D_TAIL: begin
          state_q <= S_D_GIVE;
        end
        // splice descriptor, then the whole chain, onto the free list
        S_D_GIVE: begin
          free_head_q    <= id_blk;
          live_q[id_blk] <= 1'b0;
          state_q        <= S_DONE;
        end
        S_E_GOT: begin
          if (blk_q == '0) begin
            res_status_q <= ST_NOMEM;
            state_q      <= S_DONE;
          end else begin
            t_q     <= block_base(blk_q);
            state_q <= S_E_WR;
          end
        end
        S_E_WR: begin
          state_q <= S_DONE;
        end
        // drained block goes back to the free list, follow its link
        S_Q_LINK: begin
          free_head_q <= h_q[PTR_W-1:OFS_W];
          h_q         <= block_base(link_blk);
          state_q     <= S_Q_DATA;
        end
        S_Q_DATA: begin
          res_rbyte_q <= pool_rdata;
          state_q     <= S_DONE;
        end
        S_DONE: begin
          if (res_load) begin
            m_data_q  <= {(OUT_TDATA_W - OUT_FIELDS_W)'(0), res_rbyte_q, res_newid_q,
                          res_status_q};
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  // A failed command never reports a descriptor
  `SPLQ_ASSERT_IMPL(a_nomem_no_id,
    m_valid_q && (m_data_q[STATUS_W-1:0] != ST_OK), m_data_q[STATUS_W +: ID_W] == '0)

  // The high-water counter only grows
  `SPLQ_ASSERT_NEXT(a_hw_monotonic, 1'b1, hw_q >= $past(hw_q))

  // An accepted command always leaves idle
  `SPLQ_ASSERT_NEXT(a_accept_busy, in_fire, state_q != S_IDLE)

endmodule

>>> bench/tb_shared_pool_linked_byte_queues.sv
// Self-checking testbench for shared_pool_linked_byte_queues.
// Depends on splq_pkg and the design; predicts every reply from its own pool model.
module tb_shared_pool_linked_byte_queues;
  import splq_pkg::*;

  localparam int LIMIT_CYCLES = 600000;
  localparam int TAIL_CYCLES  = 20;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    status_e            status;
    logic [ID_W-1:0]    new_id;
    logic [BYTE_W-1:0]  data;
  } reply_t;

  // Pool model, expected replies and reply checking
  class queue_pool_scoreboard;
    logic [BYTE_W-1:0] mem_bytes [POOL_BYTES];
    logic [PTR_W-1:0]  head_addr [NUM_BLOCKS];
    logic [PTR_W-1:0]  tail_addr [NUM_BLOCKS];
    bit                queue_open [NUM_BLOCKS];
    logic [BLK_W-1:0]  free_top;
    logic [BLK_W-1:0]  watermark;
    reply_t            expected_replies [$];
    reply_t            last_reply;
    int                mismatches;
    int                replies_seen;

    function new();
      foreach (mem_bytes[i]) mem_bytes[i] = '0;
      foreach (head_addr[i]) begin
        head_addr[i]  = '0;
        tail_addr[i]  = '0;
        queue_open[i] = 1'b0;
      end
      free_top     = '0;
      watermark    = '0;
      mismatches   = 0;
      replies_seen = 0;
    endfunction

    function int link_of(logic [BLK_W-1:0] blk);
      return int'(blk) * BYTES_PER_BLOCK + LINK_OFS;
    endfunction

    // Pop the free list first, then bump the watermark until it saturates
    function logic [BLK_W-1:0] grab_block();
      logic [BLK_W-1:0] blk;
      blk = free_top;
      if (blk != '0) begin
        free_top = mem_bytes[link_of(blk)];
        return blk;
      end
      if (int'(watermark) < NUM_BLOCKS - 1) begin
        watermark++;
        return watermark;
      end
      return '0;
    endfunction

    function void put_block(logic [BLK_W-1:0] blk);
      mem_bytes[link_of(blk)] = free_top;
      free_top = blk;
    endfunction

    function reply_t compute_reply(opcode_e op, logic [ID_W-1:0] id,
                                   logic [BYTE_W-1:0] val);
      reply_t            r;
      logic [BLK_W-1:0]  desc;
      logic [BLK_W-1:0]  blk;
      logic [PTR_W-1:0]  ptr;
      r.status = ST_OK;
      r.new_id = '0;
      r.data   = '0;
      if (op == OP_CREATE) begin
        desc = grab_block();
        if (desc == '0) begin
          r.status = ST_NOMEM;
        end else begin
          blk = grab_block();
          if (blk == '0) begin
            // hand the descriptor back
            put_block(desc);
            r.status = ST_NOMEM;
          end else begin
            head_addr[desc]  = PTR_W'(int'(blk) * BYTES_PER_BLOCK);
            tail_addr[desc]  = PTR_W'(int'(blk) * BYTES_PER_BLOCK);
            queue_open[desc] = 1'b1;
            r.new_id = desc;
          end
        end
      end else if (id == '0 || int'(id) >= NUM_BLOCKS || !queue_open[id]) begin
        r.status = ST_BADID;
      end else if (op == OP_DESTROY) begin
        // splice the whole chain, then the descriptor, onto the free list
        blk = BLK_W'(int'(tail_addr[id]) / BYTES_PER_BLOCK);
        mem_bytes[link_of(blk)] = free_top;
        free_top = BLK_W'(int'(head_addr[id]) / BYTES_PER_BLOCK);
        put_block(id);
        queue_open[id] = 1'b0;
      end else if (op == OP_ENQUEUE) begin
        ptr = tail_addr[id];
        if (int'(ptr) % BYTES_PER_BLOCK == LINK_OFS) begin
          blk = grab_block();
          if (blk == '0) begin
            r.status = ST_NOMEM;
          end else begin
            mem_bytes[ptr] = blk;
            ptr = PTR_W'(int'(blk) * BYTES_PER_BLOCK);
          end
        end
        if (r.status == ST_OK) begin
          mem_bytes[ptr] = val;
          tail_addr[id]  = ptr + 1'b1;
        end
      end else begin
        ptr = head_addr[id];
        if (ptr == tail_addr[id]) begin
          r.status = ST_EMPTY;
        end else begin
          // drained block: follow its link and free it
          if (int'(ptr) % BYTES_PER_BLOCK == LINK_OFS) begin
            blk = mem_bytes[ptr];
            put_block(BLK_W'(int'(ptr) / BYTES_PER_BLOCK));
            ptr = PTR_W'(int'(blk) * BYTES_PER_BLOCK);
          end
          r.data = mem_bytes[ptr];
          head_addr[id] = ptr + 1'b1;
        end
      end
      return r;
    endfunction

    function void note_command(opcode_e op, logic [ID_W-1:0] id, logic [BYTE_W-1:0] val);
      last_reply = compute_reply(op, id, val);
      expected_replies.push_back(last_reply);
    endfunction

    function void check_reply(logic [OUT_TDATA_W-1:0] word);
      reply_t want;
      reply_t got;
      got.status = status_e'(word[STATUS_W-1:0]);
      got.new_id = word[STATUS_W +: ID_W];
      got.data   = word[STATUS_W+ID_W +: BYTE_W];
      replies_seen++;
      if (expected_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("reply %0d not expected: status %0d id %0d byte %0h",
                   replies_seen, got.status, got.new_id, got.data);
        return;
      end
      want = expected_replies.pop_front();
      if (got.status !== want.status || got.new_id !== want.new_id ||
          got.data !== want.data) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("reply %0d: expected status %0d id %0d byte %0h, got status %0d id %0d byte %0h",
                   replies_seen, want.status, want.new_id, want.data,
                   got.status, got.new_id, got.data);
      end
    endfunction

    function int pending_count();
      return expected_replies.size();
    endfunction

    function int open_count();
      int n;
      n = 0;
      foreach (queue_open[i]) if (queue_open[i]) n++;
      return n;
    endfunction

    // Random live queue, or 0 when none exists
    function logic [ID_W-1:0] pick_open_queue();
      logic [ID_W-1:0] ids [$];
      for (int i = 1; i < NUM_BLOCKS; i++) if (queue_open[i]) ids.push_back(ID_W'(i));
      if (ids.size() == 0) return '0;
      return ids[$urandom_range(0, ids.size() - 1)];
    endfunction
  endclass

  logic                    clk_i;
  logic                    rst_ni  = 1'b0;
  logic                    s_valid = 1'b0;
  logic [IN_TDATA_W-1:0]   s_data  = '0;
  logic                    m_ready = 1'b0;
  logic                    s_axis_tready_o;
  logic                    m_axis_tvalid_o;
  logic [OUT_TDATA_W-1:0]  m_axis_tdata_o;
  bit                      steady  = 1'b0;

  queue_pool_scoreboard sb = new();

  shared_pool_linked_byte_queues dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Mostly short gaps, a few long ones
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 40);
  endfunction

  // Present one command and hold it until the transfer
  task automatic send_cmd(input opcode_e op, input logic [ID_W-1:0] id,
                          input logic [BYTE_W-1:0] val);
    int gap;
    gap = steady ? 0 : idle_len();
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= IN_TDATA_W'({val, id, op});
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_command(op, id, val);
  endtask

  // Hold off the sender until every reply is back
  task automatic wait_all_replies();
    s_valid <= 1'b0;
    do @(posedge clk_i); while (sb.pending_count() != 0);
  endtask

  task automatic random_cmd();
    int              r;
    logic [ID_W-1:0] id;
    r  = $urandom_range(0, 99);
    id = sb.pick_open_queue();
    if (r < 5)
      send_cmd(opcode_e'($urandom_range(0, 3)), ID_W'($urandom), BYTE_W'($urandom));
    else if (r < 19 || id == '0)
      send_cmd(OP_CREATE, ID_W'($urandom), BYTE_W'($urandom));
    else if (r < 27)
      send_cmd(OP_DESTROY, id, BYTE_W'($urandom));
    else if (r < 72)
      send_cmd(OP_ENQUEUE, id, BYTE_W'($urandom));
    else
      send_cmd(OP_DEQUEUE, id, BYTE_W'($urandom));
  endtask

  task automatic run_directed();
    logic [BYTE_W-1:0] pattern [8] = '{8'h00, 8'hFF, 8'hA5, 8'h5A, 8'h01, 8'h80, 8'h7E, 8'hC3};
    logic [ID_W-1:0]   qa;
    logic [ID_W-1:0]   qb;
    // reserved id and an id never created
    send_cmd(OP_DEQUEUE, 8'h00, 8'h00);
    send_cmd(OP_ENQUEUE, 8'hFF, 8'hFF);
    send_cmd(OP_CREATE, 8'h00, 8'h00);
    qa = sb.last_reply.new_id;
    send_cmd(OP_DEQUEUE, qa, 8'h00);
    // fill the first block, the last byte spills into a new one
    foreach (pattern[i]) send_cmd(OP_ENQUEUE, qa, pattern[i]);
    // drain across the block boundary, then hit empty
    repeat (9) send_cmd(OP_DEQUEUE, qa, 8'hFF);
    send_cmd(OP_CREATE, 8'hFF, 8'hFF);
    qb = sb.last_reply.new_id;
    send_cmd(OP_ENQUEUE, qb, 8'h3C);
    send_cmd(OP_DESTROY, qa, 8'h00);
    send_cmd(OP_ENQUEUE, qa, 8'h11);
    send_cmd(OP_DESTROY, qb, 8'hFF);
  endtask

  task automatic run_mixed(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 100 == 0) steady = ($urandom_range(0, 3) == 0);
      random_cmd();
      if ($urandom_range(0, 149) == 0) wait_all_replies();
    end
    steady = 1'b0;
  endtask

  // Run the pool dry, hit every out-of-memory path, then tear everything down
  task automatic exhaust_pool();
    logic [ID_W-1:0] fresh_q;
    logic [ID_W-1:0] full_q;
    logic [ID_W-1:0] q;
    int              n;
    int              r;
    fresh_q = '0;
    n = 0;
    do begin
      send_cmd(OP_CREATE, ID_W'($urandom), BYTE_W'($urandom));
      if (sb.last_reply.status == ST_OK) fresh_q = sb.last_reply.new_id;
      n++;
    end while (sb.last_reply.status == ST_OK && n < 300);
    full_q = sb.pick_open_queue();
    n = 0;
    while (full_q != '0 && n < 40) begin
      send_cmd(OP_ENQUEUE, full_q, BYTE_W'($urandom));
      n++;
      if (sb.last_reply.status != ST_OK) break;
    end
    // nothing left, not even a descriptor
    send_cmd(OP_CREATE, ID_W'($urandom), BYTE_W'($urandom));
    if (fresh_q != '0 && fresh_q != full_q) begin
      // free two blocks, use one, so create gets a descriptor but no data block
      send_cmd(OP_DESTROY, fresh_q, BYTE_W'($urandom));
      send_cmd(OP_ENQUEUE, full_q, BYTE_W'($urandom));
      send_cmd(OP_CREATE, ID_W'($urandom), BYTE_W'($urandom));
    end
    n = 0;
    while (sb.open_count() > 0 && n < 800) begin
      q = sb.pick_open_queue();
      r = $urandom_range(0, 9);
      if (r < 4)
        send_cmd(OP_DESTROY, q, BYTE_W'($urandom));
      else if (r < 8)
        send_cmd(OP_DEQUEUE, q, BYTE_W'($urandom));
      else
        random_cmd();
      n++;
    end
  endtask

  // Accept replies with random stalls and check each transfer
  initial begin : reply_sink
    int stall_left;
    stall_left = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_ready) sb.check_reply(m_axis_tdata_o);
      if (steady) begin
        stall_left = 0;
        m_ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        m_ready <= 1'b0;
      end else begin
        if ($urandom_range(0, 3) == 0) stall_left = idle_len();
        m_ready <= (stall_left == 0);
      end
    end
  end

  initial begin : watchdog
    repeat (LIMIT_CYCLES) @(posedge clk_i);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    run_directed();
    wait_all_replies();
    run_mixed(300);
    exhaust_pool();
    wait_all_replies();
    run_mixed(300);
    exhaust_pool();
    wait_all_replies();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_count() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+design
design/splq_pkg.sv
design/splq_ram.sv
design/shared_pool_linked_byte_queues.sv
bench/tb_shared_pool_linked_byte_queues.sv
